FILE: rtl/rbch_pkg.sv
// Shared types, constants and helpers for the ray/box closest-hit core.
package rbch_pkg;

  localparam int FIELD_W   = 21;
  localparam int REG_W     = 63;
  localparam int IDX_W     = 8;
  localparam int DIST_W    = 33;
  localparam int DELTA_W   = 22;
  localparam int PROD_W    = 43;
  localparam int E_W       = 46;
  localparam int N_W       = 46;
  localparam int DEN_W     = 44;
  localparam int QUO_W     = 34;
  localparam int T_W       = 35;
  localparam int FRAC_SH   = 16;
  localparam int CORNER_SH = 10;
  localparam int SAT_SH    = QUO_W - FRAC_SH;

  localparam logic signed [T_W-1:0] FAR_START = 35'sd6553600000;
  localparam logic signed [T_W-1:0] FAR_OVER  = 35'sd6553600001;
  localparam logic [DEN_W-1:0] PARALLEL_LIMIT = 44'd1048;

  localparam int NUM_REGS = 6;
  localparam logic [2:0] REG_ORIGIN    = 3'd0;
  localparam logic [2:0] REG_DIRECTION = 3'd1;
  localparam logic [2:0] REG_AXIS_X    = 3'd2;
  localparam logic [2:0] REG_AXIS_Y    = 3'd3;
  localparam logic [2:0] REG_AXIS_Z    = 3'd4;
  localparam logic [2:0] REG_POSITION  = 3'd5;

  typedef struct packed {
    logic [2:0][FIELD_W-1:0] lo;
    logic [2:0][FIELD_W-1:0] hi;
    logic [IDX_W-1:0]        box_index;
    logic                    test;
    logic                    last;
  } box_t;

  typedef struct packed {
    logic             start;
    logic [N_W-1:0]   num_mag;
    logic [DEN_W-1:0] den_mag;
    logic             neg;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic                  busy;
    logic signed [T_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHK,
    S_DIV_LO,
    S_DIV_HI,
    S_UPD,
    S_FIN
  } state_t;

  function automatic logic signed [FIELD_W-1:0] get_field(input logic [REG_W-1:0] v,
                                                          input logic [1:0] k);
    logic signed [FIELD_W-1:0] r;
    case (k)
      2'd0:    r = $signed(v[FIELD_W-1:0]);
      2'd1:    r = $signed(v[2*FIELD_W-1:FIELD_W]);
      2'd2:    r = $signed(v[3*FIELD_W-1:2*FIELD_W]);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ray_box_closest_hit_core.sv
// Top level: APB register file, front, queue, slab engine and shared divider.
//
//  channel | signals                              | transaction when
//  --------+--------------------------------------+------------------------------
//  box in  | in_valid/in_ready + corner, index... | in_valid && in_ready
//  result  | out_valid/out_ready + hit fields     | out_valid && out_ready
//  config  | psel/penable/pwrite/paddr/pwdata     | psel && penable && pwrite
//
// A skipped box goes straight from the idle state to the finish state. A tested box
// runs the dot products and check per axis, plus two divisions and an update state per
// non-parallel axis (34 quotient bits per slab plane in the shared divider, no bit
// steps when the quotient saturates).
// A two-entry queue lets boxes arrive while the engine works; a waiting result stalls
// only a later last box. rst is synchronous and clears the query state and registers.
module ray_box_closest_hit_core
  import rbch_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [5:0]                paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [FIELD_W-1:0] min_corner_x,
  input  logic signed [FIELD_W-1:0] min_corner_y,
  input  logic signed [FIELD_W-1:0] min_corner_z,
  input  logic signed [FIELD_W-1:0] max_corner_x,
  input  logic signed [FIELD_W-1:0] max_corner_y,
  input  logic signed [FIELD_W-1:0] max_corner_z,
  input  logic [IDX_W-1:0]          box_index,
  input  logic                      skip_box,
  input  logic                      last_box,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      hit_found,
  output logic [IDX_W-1:0]          closest_index,
  output logic [DIST_W-1:0]         hit_distance
);

  logic [REG_W-1:0] origin_reg;
  logic [REG_W-1:0] direction_reg;
  logic [REG_W-1:0] axis_x;
  logic [REG_W-1:0] axis_y;
  logic [REG_W-1:0] axis_z;
  logic [REG_W-1:0] box_position;
  logic [2:0]       reg_sel;
  logic             wr_en;

  logic     push_valid;
  logic     push_ready;
  box_t     push_data;
  logic     head_valid;
  box_t     head;
  logic     pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign pready  = 1'b1;
  assign reg_sel = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_reg    <= '0;
      direction_reg <= '0;
      axis_x        <= '0;
      axis_y        <= '0;
      axis_z        <= '0;
      box_position  <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ORIGIN:    origin_reg    <= pwdata[REG_W-1:0];
        REG_DIRECTION: direction_reg <= pwdata[REG_W-1:0];
        REG_AXIS_X:    axis_x        <= pwdata[REG_W-1:0];
        REG_AXIS_Y:    axis_y        <= pwdata[REG_W-1:0];
        REG_AXIS_Z:    axis_z        <= pwdata[REG_W-1:0];
        REG_POSITION:  box_position  <= pwdata[REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ORIGIN:    prdata = {1'b0, origin_reg};
      REG_DIRECTION: prdata = {1'b0, direction_reg};
      REG_AXIS_X:    prdata = {1'b0, axis_x};
      REG_AXIS_Y:    prdata = {1'b0, axis_y};
      REG_AXIS_Z:    prdata = {1'b0, axis_z};
      REG_POSITION:  prdata = {1'b0, box_position};
      default:       prdata = '0;
    endcase
  end

  rbch_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .min_corner_x (min_corner_x),
    .min_corner_y (min_corner_y),
    .min_corner_z (min_corner_z),
    .max_corner_x (max_corner_x),
    .max_corner_y (max_corner_y),
    .max_corner_z (max_corner_z),
    .box_index    (box_index),
    .skip_box     (skip_box),
    .last_box     (last_box),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  rbch_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  rbch_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  rbch_back u_back (
    .clk           (clk),
    .rst           (rst),
    .origin        (origin_reg),
    .direction     (direction_reg),
    .axis_x        (axis_x),
    .axis_y        (axis_y),
    .axis_z        (axis_z),
    .position      (box_position),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit_found     (hit_found),
    .closest_index (closest_index),
    .hit_distance  (hit_distance)
  );

endmodule

FILE: rtl/rbch_front.sv
// Input side: takes box transactions and classifies them for the queue.
module rbch_front
  import rbch_pkg::*;
(
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [FIELD_W-1:0] min_corner_x,
  input  logic signed [FIELD_W-1:0] min_corner_y,
  input  logic signed [FIELD_W-1:0] min_corner_z,
  input  logic signed [FIELD_W-1:0] max_corner_x,
  input  logic signed [FIELD_W-1:0] max_corner_y,
  input  logic signed [FIELD_W-1:0] max_corner_z,
  input  logic [IDX_W-1:0]          box_index,
  input  logic                      skip_box,
  input  logic                      last_box,
  output logic                      push_valid,
  input  logic                      push_ready,
  output box_t                      push_data
);

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_data.lo        = {min_corner_z, min_corner_y, min_corner_x};
    push_data.hi        = {max_corner_z, max_corner_y, max_corner_x};
    push_data.box_index = box_index;
    // skipped boxes bypass the slab test entirely
    push_data.test      = !skip_box;
    push_data.last      = last_box;
  end

endmodule

FILE: rtl/rbch_fifo.sv
// Two-entry queue between the front and the slab engine.
module rbch_fifo
  import rbch_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  box_t push_data,
  output logic head_valid,
  input  logic pop,
  output box_t head
);

  box_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;

  assign push_ready = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/rbch_div.sv
// Shared restoring divider: one quotient bit per cycle, saturating result.
module rbch_div
  import rbch_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DEN_W:0]     rem;
  logic [QUO_W-1:0]   low_bits;
  logic [QUO_W-1:0]   quo;
  logic [DEN_W-1:0]   den;
  logic               neg;
  logic               sat;
  logic               busy;
  logic [5:0]         cnt;
  logic [DEN_W:0]     trial;
  logic               sat_in;
  logic signed [T_W-1:0] q_signed;

  // quotient would not fit 34 bits: |num| * 2^16 >= den * 2^34
  assign sat_in = {18'd0, req.num_mag} >= ({20'd0, req.den_mag} << SAT_SH);
  assign trial  = {rem[DEN_W-1:0], low_bits[QUO_W-1]};

  always_comb begin
    if (neg) begin
      q_signed = -$signed({1'b0, quo});
    end else begin
      q_signed = $signed({1'b0, quo});
    end
    if (sat) begin
      q_signed = neg ? -35'sd1 : FAR_OVER;
    end
  end

  assign rsp.done = busy && (cnt == 6'd0);
  assign rsp.busy = busy;
  assign rsp.quo  = q_signed;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      if (busy && cnt != 6'd0) begin
        cnt <= cnt - 6'd1;
      end else if (busy) begin
        busy <= 1'b0;
      end
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= sat_in ? 6'd0 : 6'(QUO_W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den      <= req.den_mag;
      neg      <= req.neg;
      sat      <= sat_in;
      rem      <= (DEN_W+1)'(req.num_mag >> SAT_SH);
      low_bits <= {req.num_mag[SAT_SH-1:0], {FRAC_SH{1'b0}}};
      quo      <= '0;
    end else if (busy && cnt != 6'd0) begin
      low_bits <= low_bits << 1;
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  a_start_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (!busy || rsp.done))
    else $error("divider restarted while busy");

endmodule

FILE: rtl/rbch_back.sv
// Slab engine: dot products, slab test per axis, nearest-hit tracking, result register.
module rbch_back
  import rbch_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [REG_W-1:0]    origin,
  input  logic [REG_W-1:0]    direction,
  input  logic [REG_W-1:0]    axis_x,
  input  logic [REG_W-1:0]    axis_y,
  input  logic [REG_W-1:0]    axis_z,
  input  logic [REG_W-1:0]    position,
  input  logic                head_valid,
  input  box_t                head,
  output logic                pop,
  output div_req_t            div_req,
  input  div_rsp_t            div_rsp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                hit_found,
  output logic [IDX_W-1:0]    closest_index,
  output logic [DIST_W-1:0]   hit_distance
);

  state_t state, state_next;

  logic [1:0]                axis;
  logic [2:0]                cnt;
  logic signed [PROD_W-1:0]  prod;
  logic signed [E_W-1:0]     e_acc;
  logic signed [E_W-1:0]     f_acc;
  logic signed [T_W-1:0]     tnear;
  logic signed [T_W-1:0]     tfar;
  logic signed [T_W-1:0]     t_lo;
  logic signed [T_W-1:0]     t_hi;
  logic                      box_hit;
  logic                      any_hit;
  logic [IDX_W-1:0]          best_index;
  logic [DIST_W-1:0]         best_distance;

  logic [REG_W-1:0]          axis_reg;
  logic [1:0]                k;
  logic signed [FIELD_W-1:0] op_a;
  logic signed [DELTA_W-1:0] op_b;
  logic [DEN_W-1:0]          f_mag;
  logic                      parallel;
  logic signed [E_W-1:0]     lo20;
  logic signed [E_W-1:0]     hi20;
  logic signed [N_W-1:0]     num;
  logic                      par_reject;
  logic signed [T_W-1:0]     t_min;
  logic signed [T_W-1:0]     t_max;
  logic signed [T_W-1:0]     far_new;
  logic signed [T_W-1:0]     near_new;
  logic                      take;
  logic                      out_busy;

  always_comb begin
    case (axis)
      2'd0:    axis_reg = axis_x;
      2'd1:    axis_reg = axis_y;
      default: axis_reg = axis_z;
    endcase
  end

  // multiplier operands: cnt 0..2 build e, cnt 3..5 build f
  always_comb begin
    k = (cnt < 3'd3) ? cnt[1:0] : 2'(cnt - 3'd3);
    op_a = get_field(axis_reg, k);
    if (cnt < 3'd3) begin
      op_b = DELTA_W'(get_field(position, k)) - DELTA_W'(get_field(origin, k));
    end else begin
      op_b = DELTA_W'(get_field(direction, k));
    end
  end

  assign f_mag    = f_acc[E_W-1] ? DEN_W'(-f_acc) : DEN_W'(f_acc);
  assign parallel = (f_mag <= PARALLEL_LIMIT);
  assign lo20     = E_W'($signed(head.lo[axis])) <<< CORNER_SH;
  assign hi20     = E_W'($signed(head.hi[axis])) <<< CORNER_SH;
  assign par_reject = (lo20 > e_acc) || (hi20 < e_acc);

  assign t_min    = (t_lo > t_hi) ? t_hi : t_lo;
  assign t_max    = (t_lo > t_hi) ? t_lo : t_hi;
  assign far_new  = (t_max < tfar) ? t_max : tfar;
  assign near_new = (t_min > tnear) ? t_min : tnear;

  assign take     = box_hit && (!any_hit || DIST_W'(tnear) < best_distance);
  assign out_busy = out_valid && !out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (head_valid) begin
          state_next = head.test ? S_MUL : S_FIN;
        end
      end
      S_MUL: begin
        if (cnt == 3'd6) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (!parallel) begin
          state_next = S_DIV_LO;
        end else if (par_reject || axis == 2'd2) begin
          state_next = S_FIN;
        end else begin
          state_next = S_MUL;
        end
      end
      S_DIV_LO: begin
        if (div_rsp.done) begin
          state_next = S_DIV_HI;
        end
      end
      S_DIV_HI: begin
        if (div_rsp.done) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (far_new < near_new || axis == 2'd2) begin
          state_next = S_FIN;
        end else begin
          state_next = S_MUL;
        end
      end
      S_FIN: begin
        if (!(head.last && out_busy)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs to the divider and the queue
  always_comb begin
    num = (state == S_CHK) ? (e_acc + lo20) : (e_acc + hi20);
    div_req.start   = ((state == S_CHK) && !parallel) ||
                      ((state == S_DIV_LO) && div_rsp.done);
    div_req.num_mag = num[N_W-1] ? N_W'(-num) : N_W'(num);
    div_req.den_mag = f_mag;
    div_req.neg     = num[N_W-1] ^ f_acc[E_W-1];
    pop = (state == S_FIN) && !(head.last && out_busy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        axis    <= 2'd0;
        cnt     <= 3'd0;
        tnear   <= '0;
        tfar    <= FAR_START;
        box_hit <= 1'b0;
      end
      S_MUL: begin
        prod <= PROD_W'(op_a) * PROD_W'(op_b);
        if (cnt == 3'd0) begin
          e_acc <= '0;
          f_acc <= '0;
        end else if (cnt <= 3'd3) begin
          e_acc <= e_acc + E_W'(prod);
        end else begin
          f_acc <= f_acc + E_W'(prod);
        end
        cnt <= cnt + 3'd1;
      end
      S_CHK: begin
        cnt <= 3'd0;
        if (parallel) begin
          if (!par_reject && axis == 2'd2) begin
            box_hit <= 1'b1;
          end
          axis <= axis + 2'd1;
        end
      end
      S_DIV_LO: begin
        if (div_rsp.done) begin
          t_lo <= div_rsp.quo;
        end
      end
      S_DIV_HI: begin
        if (div_rsp.done) begin
          t_hi <= div_rsp.quo;
        end
      end
      S_UPD: begin
        tfar  <= far_new;
        tnear <= near_new;
        cnt   <= 3'd0;
        axis  <= axis + 2'd1;
        if (!(far_new < near_new) && axis == 2'd2) begin
          box_hit <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // nearest-hit state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      any_hit       <= 1'b0;
      best_index    <= '0;
      best_distance <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head.last) begin
          out_valid     <= 1'b1;
          hit_found     <= any_hit || take;
          closest_index <= take ? head.box_index : best_index;
          hit_distance  <= take ? DIST_W'(tnear) : best_distance;
          any_hit       <= 1'b0;
          best_index    <= '0;
          best_distance <= '0;
        end else if (take) begin
          any_hit       <= 1'b1;
          best_index    <= head.box_index;
          best_distance <= DIST_W'(tnear);
        end
      end
    end
  end

  // a rejected box may leave tnear past the far limit; only a hit is bounded
  a_near_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && box_hit) |-> ((tnear >= 0) && (tnear <= FAR_START)))
    else $error("near distance out of range");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last) |=> (!any_hit && best_distance == '0 && out_valid))
    else $error("query state not cleared after last box");

  a_empty_best: assert property (@(posedge clk) disable iff (rst)
    !any_hit |-> (best_index == '0 && best_distance == '0))
    else $error("best record set without a hit");

endmodule
